FILE: src/vadpcm_pkg.sv
// Package for the vector ADPCM frame decoder.
// Holds shared constants, operation codes and the MAC control struct; no dependencies.

package vadpcm_pkg;

  // Samples per group, and two groups per frame.
  localparam int unsigned GROUP_LEN  = 8;
  localparam int unsigned GIDX_W     = 3;
  // Codebook words per predictor: 8 rows by 8 taps.
  localparam int unsigned ENTRY_SIZE = 64;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned RES_W      = 19;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COEF_W     = 16;
  // Header byte that opens a frame, then eight data bytes.
  localparam logic [3:0]  LAST_BYTE  = 4'd8;
  // Dot products are scaled down by 2048.
  localparam int unsigned DOT_SHIFT  = 11;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic signed [DATA_W-1:0] SAMPLE_MAX = 32'sh0000_7fff;
  localparam logic signed [DATA_W-1:0] SAMPLE_MIN = -32'sh0000_8000;

  typedef struct packed {
    logic clr;  // zero the accumulator before a new sample
    logic vld;  // coefficient and operand are valid this cycle
  } mac_ctrl_t;

endpackage

FILE: src/vadpcm_if.sv
// Channel interfaces of the vector ADPCM frame decoder.
// Input items, result items and the configuration write; no dependencies.

interface vadpcm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  predictor_index;
  logic [2:0]  coef_row;
  logic [2:0]  coef_tap;
  logic signed [15:0] coef_value;
  logic [7:0]  frame_byte;

  modport source (output valid, operation, predictor_index, coef_row, coef_tap, coef_value,
                  frame_byte, input ready);
  modport sink   (input valid, operation, predictor_index, coef_row, coef_tap, coef_value,
                  frame_byte, output ready);
endinterface

interface vadpcm_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] sample;
  logic signed [31:0] raw_sample;
  logic        pair_last;
  logic        frame_end;

  modport source (output valid, sample, raw_sample, pair_last, frame_end, input ready);
  modport sink   (input valid, sample, raw_sample, pair_last, frame_end, output ready);
endinterface

interface vadpcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  predictor_order;

  modport source (output valid, predictor_order, input ready);
  modport sink   (input valid, predictor_order, output ready);
endinterface

FILE: src/vadpcm_mac.sv
// Shared multiply-accumulate unit of the vector ADPCM decoder.
// Uses vadpcm_pkg for widths and the control struct.

module vadpcm_mac (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vadpcm_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [vadpcm_pkg::COEF_W-1:0]   coef_i,
  input  logic        [vadpcm_pkg::DATA_W-1:0]   opb_i,
  output logic        [vadpcm_pkg::DATA_W-1:0]   acc_o,
  output logic                                   busy_o
);

  logic [vadpcm_pkg::DATA_W-1:0] coef_ext;
  logic [vadpcm_pkg::DATA_W-1:0] prod_d, prod_q;
  logic [vadpcm_pkg::DATA_W-1:0] acc_q;
  logic                          prod_vld_q;

  // Only the low 32 bits of the product are kept, so an unsigned multiply of the
  // sign-extended coefficient gives the wrapped result.
  assign coef_ext = {{(vadpcm_pkg::DATA_W-vadpcm_pkg::COEF_W){coef_i[vadpcm_pkg::COEF_W-1]}},
                     coef_i};
  assign prod_d   = coef_ext * opb_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_vld_q;

endmodule

FILE: src/vector_adpcm_frame_decoder_core.sv
// Top level of the vector ADPCM frame decoder: sequencer, codebook memory and history.
// Depends on vadpcm_pkg, the channel interfaces in vadpcm_if.sv and vadpcm_mac.
//
//   channel   modport   payload                                             handshake
//   in_i      sink      operation, predictor_index, coef_row, coef_tap,     valid/ready
//                       coef_value, frame_byte
//   out_o     source    sample, raw_sample, pair_last, frame_end            valid/ready
//   cfg_i     sink      predictor_order                                     valid/ready
//
// A load transaction or a header byte is handled in the idle state without leaving it. A data byte yields two samples;
// sample i of a group costs order + i multiply-accumulate terms through the single shared
// MAC, one term per cycle, then drains the memory read and product stages and finishes;
// no new input is taken until both samples of the byte are done.
// Reset is asynchronous and active low; it clears control state and the group history,
// but not the codebook, which must be loaded before frames that use it.
// A result waits in the output register while the next sample is computed; the sequencer
// only stalls when it has a new sample ready and that register is still full.

module vector_adpcm_frame_decoder_core #(
  parameter int unsigned MAX_PREDICTORS = 16,
  parameter int unsigned MAX_ORDER      = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vadpcm_in_if.sink     in_i,
  vadpcm_out_if.source  out_o,
  vadpcm_cfg_if.sink    cfg_i
);

  localparam int unsigned CB_DEPTH = MAX_PREDICTORS * vadpcm_pkg::ENTRY_SIZE;
  localparam int unsigned CB_AW    = $clog2(CB_DEPTH);
  // Term counter covers up to MAX_ORDER history taps plus seven earlier residuals.
  localparam int unsigned TW       = $clog2(MAX_ORDER + vadpcm_pkg::GROUP_LEN);
  localparam int unsigned GW       = vadpcm_pkg::GIDX_W;
  localparam int unsigned DW       = vadpcm_pkg::DATA_W;
  localparam int unsigned RW       = vadpcm_pkg::RES_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                       state_q;
  logic [vadpcm_pkg::CFG_W-1:0] order_cfg_q;
  logic [3:0]                   byte_pos_q;
  logic [3:0]                   scale_q;
  logic [3:0]                   pred_q;
  logic [7:0]                   byte_q;
  logic                         second_q;
  logic [GW-1:0]                samp_q;
  logic [TW-1:0]                k_q;
  logic                         bank_q;
  logic                         issue_vld_q;
  logic [DW-1:0]                opb_q;
  logic signed [vadpcm_pkg::COEF_W-1:0] coef_q;

  // Two banks of group outputs: one being written by the current group, the other
  // serving as history for it. Swapping banks replaces the copy at a group boundary.
  logic [DW-1:0]                hist_q [2][vadpcm_pkg::GROUP_LEN];
  logic [RW-1:0]                res_q  [vadpcm_pkg::GROUP_LEN];
  logic [vadpcm_pkg::COEF_W-1:0] cb_mem [CB_DEPTH];

  logic                         out_vld_q;
  logic signed [15:0]           out_sample_q;
  logic signed [DW-1:0]         out_raw_q;
  logic                         out_pl_q;
  logic                         out_fe_q;

  // Effective predictor order: zero acts as one, anything above MAX_ORDER saturates.
  logic [vadpcm_pkg::CFG_W-1:0] ord;
  always_comb begin
    priority if (order_cfg_q == '0) begin
      ord = vadpcm_pkg::CFG_W'(1);
    end else if (32'(order_cfg_q) > MAX_ORDER) begin
      ord = vadpcm_pkg::CFG_W'(MAX_ORDER);
    end else begin
      ord = order_cfg_q;
    end
  end

  // Term decode for the current sample. The first ord terms multiply history taps by
  // row i, tap t; the rest multiply earlier residuals m by row i-m-1, last tap.
  logic [TW-1:0] nterms;
  logic          is_tap;
  logic [TW-1:0] m_full;
  logic [GW-1:0] m_idx;
  logic [GW-1:0] row;
  logic [GW-1:0] tap;
  logic [3:0]    hidx_full;
  logic [DW-1:0] opb_d;
  logic [9:0]    cb_addr_full;
  logic [CB_AW-1:0] cb_raddr;
  logic [CB_AW-1:0] cb_waddr;
  logic          cb_we;

  assign nterms    = TW'(ord) + TW'(samp_q);
  assign is_tap    = k_q < TW'(ord);
  assign m_full    = k_q - TW'(ord);
  assign m_idx     = m_full[GW-1:0];
  assign row       = is_tap ? samp_q : (samp_q - m_idx - GW'(1));
  assign tap       = is_tap ? k_q[GW-1:0] : GW'(ord - vadpcm_pkg::CFG_W'(1));
  assign hidx_full = 4'(vadpcm_pkg::GROUP_LEN) - 4'(ord) + 4'(k_q[GW-1:0]);
  assign opb_d     = is_tap ? hist_q[!bank_q][hidx_full[GW-1:0]]
                            : {{(DW-RW){res_q[m_idx][RW-1]}}, res_q[m_idx]};
  assign cb_addr_full = {pred_q, row, tap};
  assign cb_raddr  = cb_addr_full[CB_AW-1:0];

  // Input handshake and load decode.
  logic in_fire;
  logic is_load;
  logic [9:0] ld_addr_full;
  assign in_i.ready   = (state_q == ST_IDLE);
  assign in_fire      = in_i.valid && in_i.ready;
  assign is_load      = (in_i.operation == vadpcm_pkg::OP_LOAD);
  assign ld_addr_full = {in_i.predictor_index, in_i.coef_row, in_i.coef_tap};
  assign cb_waddr     = ld_addr_full[CB_AW-1:0];
  assign cb_we        = in_fire && is_load &&
                        ({1'b0, in_i.predictor_index} < 5'(MAX_PREDICTORS));

  assign cfg_i.ready  = 1'b1;

  // Codebook memory: one write port for loads, one registered read port for the MAC.
  always_ff @(posedge clk_i) begin
    if (cb_we) begin
      cb_mem[cb_waddr] <= in_i.coef_value;
    end
    coef_q <= cb_mem[cb_raddr];
    opb_q  <= opb_d;
  end

  // Shared multiply-accumulate unit.
  vadpcm_pkg::mac_ctrl_t mac_ctrl;
  logic [DW-1:0]         acc;
  logic                  mac_busy;
  logic                  start_first;

  vadpcm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_q),
    .opb_i  (opb_q),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  // Finishing a sample: scale the dot product down by 2048 with floor rounding,
  // add the residual and clamp for the 16-bit output.
  logic                 out_free;
  logic                 fin;
  logic [3:0]           nib;
  logic [RW-1:0]        res_new;
  logic signed [DW-1:0] val;
  logic signed [15:0]   clamped;

  assign out_free = !out_vld_q || out_o.ready;
  assign fin      = (state_q == ST_DRAIN) && !issue_vld_q && !mac_busy && out_free;
  assign nib      = second_q ? byte_q[3:0] : byte_q[7:4];
  assign res_new  = {{(RW-4){nib[3]}}, nib} << scale_q;
  assign val      = (signed'(acc) >>> vadpcm_pkg::DOT_SHIFT) +
                    signed'({{(DW-RW){res_new[RW-1]}}, res_new});

  always_comb begin
    priority if (val > vadpcm_pkg::SAMPLE_MAX) begin
      clamped = 16'sh7fff;
    end else if (val < vadpcm_pkg::SAMPLE_MIN) begin
      clamped = -16'sh8000;
    end else begin
      clamped = val[15:0];
    end
  end

  // The accumulator is cleared whenever a new sample begins.
  assign start_first = in_fire && !is_load && (byte_pos_q != '0);
  assign mac_ctrl.clr = start_first || (fin && !second_q);
  assign mac_ctrl.vld = issue_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      order_cfg_q  <= vadpcm_pkg::CFG_W'(2);
      byte_pos_q   <= '0;
      scale_q      <= '0;
      pred_q       <= '0;
      byte_q       <= '0;
      second_q     <= 1'b0;
      samp_q       <= '0;
      k_q          <= '0;
      bank_q       <= 1'b0;
      issue_vld_q  <= 1'b0;
      out_vld_q    <= 1'b0;
      out_sample_q <= '0;
      out_raw_q    <= '0;
      out_pl_q     <= 1'b0;
      out_fe_q     <= 1'b0;
      hist_q       <= '{default: '{default: '0}};
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        order_cfg_q <= cfg_i.predictor_order;
      end

      // A taken result frees the register unless a finished sample lands in it
      // at the same edge.
      if (fin) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end

      issue_vld_q <= (state_q == ST_RUN);

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && !is_load) begin
            if (byte_pos_q == '0) begin
              // Header byte: scale shift above, predictor below.
              scale_q    <= in_i.frame_byte[7:4];
              if ({1'b0, in_i.frame_byte[3:0]} >= 5'(MAX_PREDICTORS)) begin
                pred_q <= 4'(MAX_PREDICTORS - 1);
              end else begin
                pred_q <= in_i.frame_byte[3:0];
              end
              byte_pos_q <= 4'd1;
            end else begin
              byte_q   <= in_i.frame_byte;
              second_q <= 1'b0;
              samp_q   <= {byte_pos_q[1:0] - 2'd1, 1'b0};
              k_q      <= '0;
              state_q  <= ST_RUN;
            end
          end
        end

        ST_RUN: begin
          if (k_q == nterms - TW'(1)) begin
            state_q <= ST_DRAIN;
          end else begin
            k_q <= k_q + TW'(1);
          end
        end

        ST_DRAIN: begin
          if (fin) begin
            out_sample_q         <= clamped;
            out_raw_q            <= val;
            out_pl_q             <= second_q;
            out_fe_q             <= second_q && (byte_pos_q == vadpcm_pkg::LAST_BYTE);
            hist_q[bank_q][samp_q] <= val;
            if (!second_q) begin
              second_q <= 1'b1;
              samp_q   <= samp_q + GW'(1);
              k_q      <= '0;
              state_q  <= ST_RUN;
            end else begin
              if (samp_q == GW'(vadpcm_pkg::GROUP_LEN - 1)) begin
                bank_q <= !bank_q;
              end
              if (byte_pos_q == vadpcm_pkg::LAST_BYTE) begin
                byte_pos_q <= '0;
              end else begin
                byte_pos_q <= byte_pos_q + 4'd1;
              end
              state_q <= ST_IDLE;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Residuals of the current group; read only after being written in the same group.
  always_ff @(posedge clk_i) begin
    if (fin) begin
      res_q[samp_q] <= res_new;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.sample     = out_sample_q;
  assign out_o.raw_sample = out_raw_q;
  assign out_o.pair_last  = out_pl_q;
  assign out_o.frame_end  = out_fe_q;

  // The pipeline is empty whenever the sequencer is idle.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!issue_vld_q && !mac_busy))
    else $error("MAC pipeline busy while sequencer idle");

  // A finished sample never overwrites a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> (!out_vld_q || out_o.ready))
    else $error("result register overwritten");

  // Frame position stays within header plus eight data bytes.
  a_byte_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_pos_q <= vadpcm_pkg::LAST_BYTE)
    else $error("byte position out of range");

  // The term counter never passes the number of terms of the current sample.
  a_term_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (k_q < nterms))
    else $error("term counter overran");

  // The end of a frame is always the second sample of a byte.
  a_frame_end_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_fe_q) |-> out_pl_q)
    else $error("frame end on first sample of a pair");

endmodule

FILE: bench/vadpcm_checker.sv
// Scoreboard for the vector ADPCM frame decoder: predicts every decoded sample and compares.
// Depends on vadpcm_pkg and the channel interfaces in vadpcm_if.sv; watches, never drives.

module vadpcm_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  vadpcm_in_if  in_i,
  vadpcm_out_if out_i,
  vadpcm_cfg_if cfg_i,
  output int    fail_count_o,
  output int    pending_o
);

  localparam int unsigned NUM_PRED     = 16;
  localparam int unsigned MAX_TAPS     = 8;
  localparam int unsigned NUM_REPORTED = 10;
  localparam int unsigned DW           = vadpcm_pkg::DATA_W;
  localparam int unsigned CW           = vadpcm_pkg::COEF_W;
  localparam int unsigned GLEN         = vadpcm_pkg::GROUP_LEN;

  typedef struct packed {
    logic signed [15:0]   sample;
    logic signed [DW-1:0] raw_sample;
    logic                 pair_last;
    logic                 frame_end;
  } sample_t;

  logic [CW-1:0]            coef_mem [NUM_PRED*vadpcm_pkg::ENTRY_SIZE];
  logic [DW-1:0]            history [GLEN];
  logic [DW-1:0]            group_vals [GLEN];
  logic signed [DW-1:0]     residuals [GLEN];
  logic [3:0]               byte_pos;
  logic [3:0]               shift_amt;
  logic [3:0]               cur_pred;
  logic [vadpcm_pkg::CFG_W-1:0] order_reg;
  sample_t                  sample_q [$];
  int                       fail_count;

  function automatic int unsigned used_order();
    int unsigned o;
    o = 32'(order_reg);
    if (o == 0) o = 1;
    if (o > MAX_TAPS) o = MAX_TAPS;
    return o;
  endfunction

  // Coefficient of the active predictor, sign extended to the accumulator width.
  function automatic logic [DW-1:0] coef_ext(int unsigned row, int unsigned tap);
    logic [CW-1:0] w;
    w = coef_mem[{cur_pred, row[2:0], tap[2:0]}];
    return {{(DW-CW){w[CW-1]}}, w};
  endfunction

  function automatic sample_t decode_nibble(int unsigned idx, logic [3:0] nib);
    int unsigned          ord;
    logic [DW-1:0]        acc;
    logic [DW-1:0]        val;
    logic signed [DW-1:0] res;
    sample_t              s;
    ord = used_order();
    res = {{(DW-4){nib[3]}}, nib};
    res = res <<< shift_amt;
    acc = '0;
    for (int unsigned t = 0; t < ord; t++) begin
      acc = acc + coef_ext(idx, t) * history[GLEN - ord + t];
    end
    // Residuals already decoded in this group feed later samples of the same group.
    for (int unsigned m = 0; m < idx; m++) begin
      acc = acc + coef_ext(idx - m - 1, ord - 1) * residuals[m];
    end
    val = ($signed(acc) >>> vadpcm_pkg::DOT_SHIFT) + res;
    group_vals[idx] = val;
    residuals[idx]  = res;
    if ($signed(val) > vadpcm_pkg::SAMPLE_MAX) s.sample = 16'sh7fff;
    else if ($signed(val) < vadpcm_pkg::SAMPLE_MIN) s.sample = 16'sh8000;
    else s.sample = val[15:0];
    s.raw_sample = val;
    s.pair_last  = 1'b0;
    s.frame_end  = 1'b0;
    return s;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [3:0]  slot;
    int unsigned first;
    logic        last;
    sample_t     s;
    if (byte_pos == 0) begin
      shift_amt = b[7:4];
      cur_pred  = b[3:0];
      byte_pos  = 4'd1;
    end else begin
      slot  = byte_pos - 4'd1;
      first = 2 * slot[1:0];
      last  = (byte_pos == vadpcm_pkg::LAST_BYTE);
      s = decode_nibble(first, b[7:4]);
      sample_q.push_back(s);
      s = decode_nibble(first + 1, b[3:0]);
      s.pair_last = 1'b1;
      s.frame_end = last;
      sample_q.push_back(s);
      if (slot[1:0] == 2'd3) begin
        for (int unsigned k = 0; k < GLEN; k++) history[k] = group_vals[k];
      end
      byte_pos = last ? 4'd0 : byte_pos + 4'd1;
    end
  endfunction

  always @(posedge clk_i) begin
    sample_t want;
    sample_t got;
    if (!rst_ni) begin
      sample_q.delete();
      for (int unsigned k = 0; k < GLEN; k++) begin
        history[k]    = '0;
        group_vals[k] = '0;
        residuals[k]  = '0;
      end
      byte_pos   = '0;
      shift_amt  = '0;
      cur_pred   = '0;
      order_reg  = 4'd2;
      fail_count = 0;
    end else begin
      // Results are checked before this edge's input is predicted, so a result can never
      // be matched against an expectation created by the same edge.
      if (out_i.valid && out_i.ready) begin
        got.sample     = out_i.sample;
        got.raw_sample = out_i.raw_sample;
        got.pair_last  = out_i.pair_last;
        got.frame_end  = out_i.frame_end;
        if (sample_q.size() == 0) begin
          if (fail_count < NUM_REPORTED)
            $display("unexpected sample %0d raw %0d pair_last %0b frame_end %0b",
                     got.sample, got.raw_sample, got.pair_last, got.frame_end);
          fail_count++;
        end else begin
          want = sample_q.pop_front();
          if (got !== want) begin
            if (fail_count < NUM_REPORTED)
              $display("mismatch: sample %0d/%0d raw %0d/%0d pair_last %0b/%0b frame_end %0b/%0b",
                       want.sample, got.sample, want.raw_sample, got.raw_sample,
                       want.pair_last, got.pair_last, want.frame_end, got.frame_end);
            fail_count++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) order_reg = cfg_i.predictor_order;
      if (in_i.valid && in_i.ready) begin
        if (in_i.operation == vadpcm_pkg::OP_LOAD)
          coef_mem[{in_i.predictor_index, in_i.coef_row, in_i.coef_tap}] = in_i.coef_value;
        else
          predict_byte(in_i.frame_byte);
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= sample_q.size();
  end

endmodule

FILE: bench/tb.sv
// Top of the vector ADPCM frame decoder testbench: clock, reset, stimulus and verdict.
// Depends on vadpcm_pkg, vadpcm_if.sv, the decoder core and the scoreboard in vadpcm_checker.sv.

module tb;

  // Input transactions in the whole run, the directed part included.
  localparam int unsigned ITEM_TARGET   = 450;
  // Cycles without any transaction before the run is declared hung. The slowest legal
  // stretch is a long sender gap, the slowest data byte and a long output stall in a row.
  localparam int unsigned IDLE_LIMIT    = 3000;
  // Cycles waited after the last expected sample, so that the core is certainly idle.
  localparam int unsigned SETTLE_CYCLES = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  vadpcm_in_if  in_if ();
  vadpcm_out_if out_if ();
  vadpcm_cfg_if cfg_if ();

  int          fail_count;
  int          pending;
  // One bit per codebook word that has been loaded, so that no frame ever reads a word
  // that was never written.
  logic [63:0] coef_written [16];
  int unsigned taps_now;
  int unsigned items_sent;
  int unsigned in_quiet;
  int unsigned out_quiet;
  int unsigned stall_cycles;
  int unsigned ready_run;
  int unsigned ready_gap;
  logic [3:0]  order_plan [5] = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15};
  logic [7:0]  corner_bytes [8] = '{8'h77, 8'h88, 8'hff, 8'h00, 8'h80, 8'h08, 8'h7f, 8'hf7};

  vector_adpcm_frame_decoder_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  vadpcm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .cfg_i        (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // An order of zero acts as one and anything above eight acts as eight.
  function automatic int unsigned clamp_order(logic [3:0] o);
    if (o == 4'd0) return 1;
    if (o > 4'd8) return 8;
    return 32'(o);
  endfunction

  // Idle gap in cycles: mostly none or short, a few long, and now and then a quiet
  // stretch of many transactions with no gap at all.
  function automatic int unsigned pick_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [15:0] pick_coef();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'sh7fff;
    if (r < 8) return 16'sh8000;
    if (r < 12) return 16'sh0800;
    if (r < 15) return 16'sh0000;
    if (r < 30) return 16'($urandom());
    // Realistic predictor coefficients stay within about two in Q11.
    return 16'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic logic [7:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hff;
    if (r < 15) return 8'h88;
    if (r < 20) return 8'h77;
    return 8'($urandom());
  endfunction

  // Small scale shifts keep the history in a useful range; large ones drive the clamp.
  function automatic logic [3:0] pick_shift();
    if ($urandom_range(0, 99) < 70) return 4'($urandom_range(0, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic bit pred_ready(logic [3:0] p, int unsigned ord);
    for (int unsigned row = 0; row < 8; row++) begin
      for (int unsigned tap = 0; tap < ord; tap++) begin
        if (!coef_written[p][row*8 + tap]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Mostly reuse a predictor that is already loaded for the order in force; otherwise
  // take any predictor and let the frame load what it is missing.
  function automatic logic [3:0] pick_predictor();
    logic [3:0] p;
    if ($urandom_range(0, 99) < 90) begin
      for (int unsigned k = 0; k < 16; k++) begin
        p = 4'($urandom());
        if (pred_ready(p, taps_now)) return p;
      end
    end
    return 4'($urandom());
  endfunction

  // Drives one input transaction at a falling edge and holds it until it is accepted.
  // The payload fields that the operation does not use carry random values.
  task automatic send_item(logic op, logic [3:0] p, logic [2:0] row, logic [2:0] tap,
                           logic signed [15:0] val, logic [7:0] b);
    int unsigned gap;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.operation       = op;
    in_if.predictor_index = p;
    in_if.coef_row        = row;
    in_if.coef_tap        = tap;
    in_if.coef_value      = val;
    in_if.frame_byte      = b;
    in_if.valid           = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (op == vadpcm_pkg::OP_LOAD) coef_written[p][{row, tap}] = 1'b1;
  endtask

  task automatic send_load(logic [3:0] p, logic [2:0] row, logic [2:0] tap,
                           logic signed [15:0] val);
    send_item(vadpcm_pkg::OP_LOAD, p, row, tap, val, 8'($urandom()));
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(vadpcm_pkg::OP_BYTE, 4'($urandom()), 3'($urandom()), 3'($urandom()),
              16'($urandom()), b);
  endtask

  task automatic random_load();
    send_load(4'($urandom()), 3'($urandom()), 3'($urandom()), pick_coef());
  endtask

  // Loads every word that predictor p needs at order ord and that is still unwritten.
  task automatic fill_codebook(logic [3:0] p, int unsigned ord);
    for (int unsigned row = 0; row < 8; row++) begin
      for (int unsigned tap = 0; tap < ord; tap++) begin
        if (!coef_written[p][row*8 + tap]) send_load(p, 3'(row), 3'(tap), pick_coef());
      end
    end
  endtask

  // Stops sending, waits for every expected sample and lets the core settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_order(logic [3:0] o);
    wait_idle();
    @(negedge clk_i);
    cfg_if.predictor_order = o;
    cfg_if.valid           = 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    taps_now = clamp_order(o);
  endtask

  // One well-formed frame with random content. Stray loads may land between data bytes,
  // and with retune set the order changes in the middle of the frame.
  task automatic send_frame(logic [3:0] shift, logic [3:0] p, bit retune);
    logic [3:0] next_order;
    fill_codebook(p, taps_now);
    send_byte({shift, p});
    for (int unsigned k = 0; k < 8; k++) begin
      if ($urandom_range(0, 99) < 10) random_load();
      if (retune && k == 4) begin
        next_order = 4'($urandom());
        fill_codebook(p, clamp_order(next_order));
        write_order(next_order);
      end
      send_byte(pick_data());
    end
  endtask

  // Output side: ready runs of random length with random stalls between them, and now
  // and then a long run with no stall at all.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      ready_run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 8);
      @(negedge clk_i);
      out_if.ready = 1'b1;
      repeat (ready_run - 1) @(negedge clk_i);
      ready_gap = pick_gap(out_quiet);
      if (ready_gap > 0) begin
        @(negedge clk_i);
        out_if.ready = 1'b0;
        repeat (ready_gap - 1) @(negedge clk_i);
      end
    end
  end

  // The watchdog counts cycles in which no transaction happens on any channel.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_if.valid            = 1'b0;
    in_if.operation        = vadpcm_pkg::OP_LOAD;
    in_if.predictor_index  = '0;
    in_if.coef_row         = '0;
    in_if.coef_tap         = '0;
    in_if.coef_value       = '0;
    in_if.frame_byte       = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.predictor_order = '0;
    for (int unsigned k = 0; k < 16; k++) coef_written[k] = '0;
    taps_now   = 2;
    items_sent = 0;
    in_quiet   = 0;
    out_quiet  = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. The coefficient field extremes go to the corner words of the
    // codebook; tap seven lies above the reset order of two, so it is stored but unused.
    send_load(4'd15, 3'd7, 3'd7, 16'sh7fff);
    send_load(4'd0, 3'd0, 3'd0, 16'sh8000);
    fill_codebook(4'd0, taps_now);

    // A frame at the smallest scale with the extreme nibble codes.
    send_byte(8'h00);
    for (int unsigned k = 0; k < 8; k++) send_byte(corner_bytes[k]);

    // The largest scale pushes the output into both clamps. Within the frame a load
    // rewrites a coefficient in use and the order drops to one between two bytes.
    send_byte(8'hf0);
    for (int unsigned k = 0; k < 8; k++) begin
      if (k == 2) send_load(4'd0, 3'd0, 3'd0, 16'sh0800);
      if (k == 5) write_order(4'd1);
      send_byte(corner_bytes[7 - k]);
    end

    // Random part: phases with different orders, the extremes and the out-of-range
    // values first, each phase a few frames long.
    for (int unsigned phase = 0; items_sent < ITEM_TARGET; phase++) begin
      write_order(phase < 5 ? order_plan[phase] : 4'($urandom()));
      repeat ($urandom_range(2, 5)) begin
        if (items_sent < ITEM_TARGET)
          send_frame(pick_shift(), pick_predictor(), $urandom_range(0, 19) == 0);
      end
    end

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
